// ===== rtl/rieu_pkg.sv =====
// ----------------------------------------------------------------------------
// rieu_pkg
// types, codes and helpers shared by the integer execute unit
// ----------------------------------------------------------------------------
`default_nettype none
package rieu_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned DivStages = 32;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_TRAP = 3'd1;
  localparam logic [2:0] ST_DIVZ = 3'd2;
  localparam logic [2:0] ST_ILL  = 3'd3;
  localparam logic [2:0] ST_NOTH = 3'd4;
  localparam logic [2:0] ST_NOP  = 3'd5;
  localparam logic [8:0] DIVZ_VECTOR = 9'd6;

  localparam logic [1:0] K_VAL  = 2'd0;
  localparam logic [1:0] K_MUL  = 2'd1;
  localparam logic [1:0] K_DIV  = 2'd2;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] src1_value;
    logic [31:0] src2_value;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  dest_reg;
    logic        write_enable;
    logic [31:0] result_value;
    logic [2:0]  status;
    logic [8:0]  exc_vector;
  } out_word_t;

  // decoded item carried down the pipe
  typedef struct packed {
    logic [4:0]  dest_reg;
    logic [2:0]  status;
    logic [8:0]  exc_vector;
    logic [1:0]  kind;
    logic        neg;
    logic [31:0] val;
    logic [31:0] opa;
    logic [31:0] opb;
  } dec_t;

  function automatic logic [31:0] cmp_word(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] v;
    logic signed [31:0] sa;
    logic signed [31:0] sb;
    begin
      sa = a;
      sb = b;
      v = 32'h2;
      v[2] = (a == b);   v[3] = (a != b);
      v[4] = (sa > sb);  v[5] = !(sa > sb);
      v[6] = (sa < sb);  v[7] = !(sa < sb);
      v[8] = (a > b);    v[9] = !(a > b);
      v[10] = (a < b);   v[11] = !(a < b);
      return v;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rieu_decode.sv =====
// ----------------------------------------------------------------------------
// rieu_decode
// decodes one word and computes every result except multiply and divide
// ----------------------------------------------------------------------------
`default_nettype none
module rieu_decode import rieu_pkg::*; (
  input  wire in_word_t w,
  output dec_t         d
);
  logic [5:0]  op, sub;
  logic [31:0] a, b, imm, m, fm, v, sh;
  logic [4:0]  wd, off;
  logic        fire;

  always_comb begin
    op  = w.instruction[31:26];
    sub = w.instruction[15:10];
    a   = w.src1_value;
    imm = {16'h0, w.instruction[15:0]};
    d = '0;
    d.dest_reg = w.instruction[25:21];
    d.status = ST_NOTH;
    d.kind = K_VAL;
    v = '0;
    fire = 1'b0;
    b = (op == 6'h3D) ? w.src2_value : imm;
    wd  = (op == 6'h3D) ? w.src2_value[9:5] : w.instruction[9:5];
    off = (op == 6'h3D) ? w.src2_value[4:0] : w.instruction[4:0];
    m = (wd == 5'd0) ? 32'hFFFFFFFF : ((32'd1 << wd) - 32'd1);
    fm = m << off;
    sh = a >> off;
    if (op >= 6'h10 && op < 6'h20 || op == 6'h3D && sub >= 6'h10 && sub < 6'h20) begin
      logic [5:0] s;
      logic ii;
      s = (op == 6'h3D) ? sub : op;
      ii = (op != 6'h3D);
      d.status = ST_OK;
      case (s)
        6'h10: v = ii ? (a & (32'hFFFF0000 | b)) : (a & b);
        6'h11: v = ii ? (a & (32'h0000FFFF | (b << 16))) : (a & ~b);
        6'h12: begin v = a & b; if (!ii) d.status = ST_ILL; end
        6'h13: begin v = a & (b << 16); if (!ii) d.status = ST_ILL; end
        6'h14: v = a ^ b;
        6'h15: v = ii ? (a ^ (b << 16)) : (a ^ ~b);
        6'h16: v = a | b;
        6'h17: v = ii ? (a | (b << 16)) : (a | ~b);
        6'h18, 6'h1C: v = a + b;
        6'h19, 6'h1D: v = a - b;
        6'h1A, 6'h1E: begin
          if (b == 32'd0) begin
            d.status = ST_DIVZ;
            d.exc_vector = DIVZ_VECTOR;
          end else begin
            d.kind = K_DIV;
            d.neg = (s == 6'h1E) && (a[31] ^ b[31]);
            d.opa = (s == 6'h1E && a[31]) ? -a : a;
            d.opb = (s == 6'h1E && b[31]) ? -b : b;
          end
        end
        6'h1B: begin d.kind = K_MUL; d.opa = a; d.opb = b; end
        default: v = cmp_word(a, b);
      endcase
    end else if (op == 6'h3C && (sub == 6'h34 || sub == 6'h36 || sub == 6'h3A)) begin
      case (sub)
        6'h34: fire = !a[d.dest_reg];
        6'h36: fire = a[d.dest_reg];
        default: fire = (a == 32'd0) ? d.dest_reg[1] :
                        (a == 32'h80000000) ? d.dest_reg[3] :
                        a[31] ? d.dest_reg[2] : d.dest_reg[0];
      endcase
      d.status = fire ? ST_TRAP : ST_NOP;
      d.exc_vector = fire ? w.instruction[8:0] : 9'd0;
    end else if (op == 6'h3C || op == 6'h3D && sub >= 6'h20 && sub <= 6'h2A) begin
      d.status = ST_OK;
      case (sub)
        6'h26: v = sh & m;
        6'h24: begin
          v = sh & m;
          if (wd != 5'd0 && v[wd - 5'd1]) v = v | ~m;
        end
        6'h28: v = (a & m) << off;
        6'h20: v = a & ~fm;
        6'h22: v = a | fm;
        6'h2A: v = (a >> off) | (a << (6'd32 - {1'b0, off}));
        default: d.status = ST_NOP;
      endcase
    end else if (op == 6'h3D) begin
      if (sub < 6'h10 || sub >= 6'h30 && sub <= 6'h33 || sub == 6'h3F) d.status = ST_NOTH;
      else if (sub == 6'h3A || sub == 6'h3B) begin
        logic [31:0] x;
        x = (sub == 6'h3B) ? ~w.src2_value : w.src2_value;
        d.status = ST_OK;
        v = 32'd32;
        for (int i = 0; i < 32; i++) if (x[i]) v = 32'(i);
      end else d.status = ST_ILL;
    end else if (op >= 6'h22 && op <= 6'h2F || op == 6'h38 || op == 6'h39 || op >= 6'h3E) begin
      d.status = ST_ILL;
    end
    d.val = (d.status == ST_OK) ? v : 32'd0;
  end
endmodule
`default_nettype wire

// ===== rtl/rieu_div_stage.sv =====
// ----------------------------------------------------------------------------
// rieu_div_stage
// one restoring divide step
// ----------------------------------------------------------------------------
`default_nettype none
module rieu_div_stage import rieu_pkg::*; (
  input  wire logic [63:0] rq_in,
  input  wire logic [31:0] dvs,
  output logic      [63:0] rq_out
);
  logic [63:0] t;
  logic [32:0] diff;
  always_comb begin
    t = rq_in << 1;
    diff = {1'b0, t[63:32]} - {1'b0, dvs};
    rq_out = t;
    if (!diff[32]) begin
      rq_out[63:32] = diff[31:0];
      rq_out[0] = 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/risc_integer_execute_unit_core.sv =====
// ----------------------------------------------------------------------------
// risc_integer_execute_unit_core
// pipelined integer execute unit
// ----------------------------------------------------------------------------
// channel | direction | handshake
// in      | input     | in_valid / in_stall, in_word
// out     | output    | out_valid / out_stall, out_word
// one word per cycle while no valid output is stalled; a word passes the decode
// register, Stages divide steps that also carry the multiply, and the output
// register before out_valid rises; the divider is one restoring step per stage
// reset clears the valid bits; the pipe advances unless a valid output is stalled
`default_nettype none
module risc_integer_execute_unit_core import rieu_pkg::*; (
  input  wire  logic      clk,
  input  wire  logic      rst,
  input  wire  logic      in_valid,
  output logic            in_stall,
  input  wire  in_word_t  in_word,
  output logic            out_valid,
  input  wire  logic      out_stall,
  output out_word_t       out_word
);
  localparam int unsigned Stages = DivStages;

  dec_t        dec;
  logic        adv;
  logic        vld [Stages+1];
  dec_t        pd  [Stages+1];
  logic [63:0] rq  [Stages+1];
  logic [63:0] rq_n [Stages];
  logic [31:0] prod;
  logic [31:0] q;

  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  rieu_decode u_dec (.w(in_word), .d(dec));

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (adv) vld[0] <= in_valid;
    if (adv) begin
      pd[0] <= dec;
      rq[0] <= {32'd0, dec.opa};
    end
  end

  for (genvar g = 0; g < Stages; g++) begin : g_div
    dec_t pd_next;
    rieu_div_stage u_st (.rq_in(rq[g]), .dvs(pd[g].opb), .rq_out(rq_n[g]));
    always_comb begin
      pd_next = pd[g];
      if (g == 0 && pd[g].kind == K_MUL) pd_next.val = pd[g].opa * pd[g].opb;
    end
    always_ff @(posedge clk) begin
      if (rst) vld[g+1] <= 1'b0;
      else if (adv) vld[g+1] <= vld[g];
      if (adv) begin
        pd[g+1] <= pd_next;
        rq[g+1] <= rq_n[g];
      end
    end
  end

  assign prod = pd[Stages].val;
  assign q = pd[Stages].neg ? -rq[Stages][31:0] : rq[Stages][31:0];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vld[Stages];
    if (adv) begin
      out_word.dest_reg     <= pd[Stages].dest_reg;
      out_word.write_enable <= (pd[Stages].status == ST_OK);
      out_word.status       <= pd[Stages].status;
      out_word.exc_vector   <= pd[Stages].exc_vector;
      out_word.result_value <= (pd[Stages].kind == K_DIV) ? q : prod;
    end
  end

`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output changed under stall");
  a_we_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.write_enable == (out_word.status == ST_OK))
    else $error("write enable mismatch");
  a_nowrite_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.write_enable |-> out_word.result_value == 32'd0)
    else $error("value without write");
`endif
endmodule
`default_nettype wire
